>>> hw/rtl/imd_pkg.sv
// Shared types, codes and constants of the insulation monitor PWM decoder.
`default_nettype none

package imd_pkg;

    // Default width of the captured period and high-time counts.
    localparam int COUNT_WIDTH_DEF = 16;

    // Configuration register indexes.
    localparam logic CFG_IDX_CLOCK = 1'b0;
    localparam logic CFG_IDX_PRESC = 1'b1;

    localparam int CLOCK_W = 27;
    localparam int PRESC_W = 16;
    localparam logic [CLOCK_W-1:0] CLOCK_RST = 27'd36000000;
    localparam logic [PRESC_W-1:0] PRESC_RST = 16'd719;

    // Result field widths.
    localparam int STATE_W = 3;
    localparam int RES_W   = 16;

    localparam logic [RES_W-1:0] RES_UNMEASURED = 16'd50000;
    localparam logic [RES_W-1:0] RES_OFFSET     = 16'd1200;
    localparam logic [RES_W-1:0] FAULT_LIMIT    = 16'd80;
    localparam int               RES_SCALE      = 21600;

    // Shared divider: quotient width and step counts of both divisions.
    localparam int DIV_STEP_W = 5;
    localparam int QUOT_W     = 16;
    localparam int FREQ_SHIFT = 6;
    localparam int RES_SHIFT  = 15;
    localparam logic [DIV_STEP_W-1:0] FREQ_STEPS = 5'd7;
    localparam logic [DIV_STEP_W-1:0] RES_STEPS  = 5'd16;

    // Frequencies in Hz that carry a meaning.
    localparam logic [FREQ_SHIFT-1:0] FREQ_NONE   = 6'd0;
    localparam logic [FREQ_SHIFT-1:0] FREQ_NORMAL = 6'd10;
    localparam logic [FREQ_SHIFT-1:0] FREQ_UNDERV = 6'd20;
    localparam logic [FREQ_SHIFT-1:0] FREQ_SPEED  = 6'd30;
    localparam logic [FREQ_SHIFT-1:0] FREQ_DEVERR = 6'd40;
    localparam logic [FREQ_SHIFT-1:0] FREQ_EARTH  = 6'd50;

    typedef enum logic [STATE_W-1:0] {
        DS_OFF       = 3'd0,
        DS_NORMAL    = 3'd1,
        DS_UNDERVOLT = 3'd2,
        DS_SPEED     = 3'd3,
        DS_DEV_ERR   = 3'd4,
        DS_EARTH     = 3'd5,
        DS_MEAS_ERR  = 3'd6
    } dev_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FLOAD,
        S_FDIV,
        S_CLASS,
        S_RDIV,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic                  load;
        logic [DIV_STEP_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        dev_state_t st;
        logic       need_res;
        logic       spd_high;
    } cls_t;

endpackage

`default_nettype wire

>>> hw/rtl/insulation_monitor_pwm_decoder_top.sv
// Top level of the insulation monitor PWM decoder: sequencer, registers and ports.
//
//  channel  | dir | handshake                   | content
//  ---------+-----+-----------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | period_ticks, high_ticks, pin_level
//  m_axis   | out | m_axis_tvalid/m_axis_tready | device_state, resistance_kohm, fault
//  cfg      | in  | cfg_valid/cfg_ready         | cfg_addr 0 timer clock Hz, 1 prescaler
//
// One item is worked on at a time. Each item passes through the shared shift-subtract
// divider: 7 steps for the frequency, then 16 steps for the resistance quotient when the
// insulation resistance is measured (normal or undervoltage state).
// The result sits in an output register, so a new item is accepted while it waits;
// a stalled output holds the sequencer in its last state until the register frees.
// Reset clears the sequencer, the output valid flag, the held resistance (50000 kiloohms),
// the held fault flag and the configuration registers to their defaults.
`default_nettype none

module insulation_monitor_pwm_decoder_top
    import imd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // period_ticks, high_ticks, pin_level from bit 0 up, zero padded to whole bytes
    input  wire logic [((2*COUNT_WIDTH+1+7)/8)*8-1:0]     s_axis_tdata,

    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // device_state [2:0], resistance_kohm [18:3], fault [19], zero padded to 24 bits
    output logic [23:0]                                   m_axis_tdata,

    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic                                     cfg_addr,
    input  wire logic [CLOCK_W-1:0]                       cfg_data
);

    localparam int CW   = COUNT_WIDTH;
    localparam int PW   = CW + PRESC_W + 1;   // prescaler + 1 times period
    localparam int DW   = CW + 23;            // divider working width
    localparam int NUMW = CW + 15;            // 21600 times period
    localparam int DENW = CW + 5;             // 20 times high minus period

    // Configuration.
    logic [CLOCK_W-1:0] clk_hz_reg;
    logic [PRESC_W-1:0] presc_reg;

    // Sequencer.
    seq_state_t state_reg;
    seq_state_t state_next;

    // Captured item and intermediate results.
    logic [CW-1:0] p_reg;
    logic [CW-1:0] h_reg;
    logic          pin_reg;
    logic [PW-1:0] prod_reg;
    dev_state_t    st_reg;
    logic          need_res_reg;
    logic          spd_high_reg;

    // Held values and output register.
    logic [RES_W-1:0] held_res_reg;
    logic             held_fault_reg;
    logic             out_valid_reg;
    dev_state_t       out_st_reg;
    logic [RES_W-1:0] out_res_reg;
    logic             out_fault_reg;

    // Divider hookup.
    div_ctl_t          div_ctl;
    div_stat_t         div_stat;
    logic [DW-1:0]     div_dividend;
    logic [DW-1:0]     div_divisor;
    logic [QUOT_W-1:0] quot;

    cls_t              cls;
    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [NUMW-1:0]   res_num;
    logic [DENW-1:0]   res_den;
    logic [PRESC_W:0]  presc_p1;
    logic [RES_W-1:0]  res_calc;
    logic              fault_calc;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (state_reg == S_OUT) && out_free;

    assign s_axis_tready = state_reg == S_IDLE;
    assign cfg_ready     = 1'b1;

    // Configuration writes are taken in any cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= CLOCK_RST;
            presc_reg  <= PRESC_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                CFG_IDX_CLOCK: clk_hz_reg <= cfg_data;
                CFG_IDX_PRESC: presc_reg  <= cfg_data[PRESC_W-1:0];
                default:       clk_hz_reg <= clk_hz_reg;
            endcase
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = accept ? S_MUL : S_IDLE;
            S_MUL:   state_next = S_FLOAD;
            S_FLOAD: state_next = S_FDIV;
            S_FDIV:  state_next = div_stat.done ? S_CLASS : S_FDIV;
            S_CLASS: state_next = cls.need_res ? S_RDIV : S_OUT;
            S_RDIV:  state_next = div_stat.done ? S_OUT : S_RDIV;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Divider operands: frequency division, then resistance division.
    assign presc_p1 = {1'b0, presc_reg} + (PRESC_W + 1)'(1);
    assign res_num  = NUMW'(p_reg) * NUMW'(RES_SCALE);
    assign res_den  = DENW'(h_reg) * DENW'(20) - DENW'(p_reg);

    // Sequencer outputs.
    always_comb
    begin
        div_ctl.load  = 1'b0;
        div_ctl.steps = FREQ_STEPS;
        div_dividend  = DW'(clk_hz_reg);
        div_divisor   = DW'(prod_reg) << FREQ_SHIFT;
        case (state_reg)
            S_FLOAD:
            begin
                div_ctl.load = 1'b1;
            end
            S_CLASS:
            begin
                div_ctl.load  = cls.need_res;
                div_ctl.steps = RES_STEPS;
                div_dividend  = DW'(res_num);
                div_divisor   = DW'(res_den) << RES_SHIFT;
            end
            default:
            begin
                div_ctl.load = 1'b0;
            end
        endcase
    end

    imd_div_unit #(
        .W (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quot     (quot)
    );

    // In the class state the divider holds the frequency quotient.
    imd_classify #(
        .COUNT_WIDTH (CW)
    ) u_cls (
        .period_ticks (p_reg),
        .high_ticks   (h_reg),
        .pin_level    (pin_reg),
        .freq_quot    (quot[FREQ_SHIFT:0]),
        .cls          (cls)
    );

    // Item capture and intermediate registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg   <= s_axis_tdata[CW-1:0];
            h_reg   <= s_axis_tdata[2*CW-1:CW];
            pin_reg <= s_axis_tdata[2*CW];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PW'(presc_p1) * PW'(p_reg);
        end
        if (state_reg == S_CLASS)
        begin
            st_reg       <= cls.st;
            need_res_reg <= cls.need_res;
            spd_high_reg <= cls.spd_high;
        end
    end

    // Resistance from the quotient, clamped at zero, and the fault decision.
    always_comb
    begin
        res_calc = RES_UNMEASURED;
        if (need_res_reg)
        begin
            res_calc = (quot >= RES_OFFSET) ? quot - RES_OFFSET : '0;
        end
        fault_calc = (st_reg == DS_SPEED && spd_high_reg) || st_reg == DS_EARTH ||
                     res_calc < FAULT_LIMIT;
    end

    // Held values and output register; a measurement error reports the held values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_res_reg   <= RES_UNMEASURED;
            held_fault_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (st_reg != DS_MEAS_ERR)
                begin
                    held_res_reg   <= res_calc;
                    held_fault_reg <= fault_calc;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_st_reg <= st_reg;
            if (st_reg == DS_MEAS_ERR)
            begin
                out_res_reg   <= held_res_reg;
                out_fault_reg <= held_fault_reg;
            end
            else
            begin
                out_res_reg   <= res_calc;
                out_fault_reg <= fault_calc;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_fault_reg, out_res_reg, out_st_reg};

    // The divider is never left running while the block waits for an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_stat.busy)
        else $error("divider busy while idle");

    // A delivered non-error result matches the held values it stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_st_reg != DS_MEAS_ERR |->
            held_res_reg == out_res_reg && held_fault_reg == out_fault_reg)
        else $error("held values disagree with the result");

    // A resistance is either unmeasured or below the top of its range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_res_reg <= 16'd52800)
        else $error("resistance out of range");

    // An earth fault always carries the fault flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_st_reg == DS_EARTH |-> out_fault_reg)
        else $error("earth fault without fault flag");

    // The resistance division starts only for normal or undervoltage items.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RDIV |-> st_reg == DS_NORMAL || st_reg == DS_UNDERVOLT)
        else $error("resistance division in a wrong state");

endmodule

`default_nettype wire

>>> hw/rtl/imd_div_unit.sv
// Shared shift-subtract divider, one quotient bit per cycle.
`default_nettype none

module imd_div_unit
    import imd_pkg::*;
#(
    parameter int W = COUNT_WIDTH_DEF + 23
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_ctl_t          ctl,
    input  wire logic [W-1:0]      dividend,
    input  wire logic [W-1:0]      divisor,   // already aligned to the top quotient bit
    output div_stat_t              stat,
    output logic      [QUOT_W-1:0] quot
);

    logic [W-1:0]          rem_reg;
    logic [W-1:0]          dsh_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic                  ge;

    assign ge = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.load)
        begin
            cnt_reg <= ctl.steps;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - DIV_STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg  <= dividend;
            dsh_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign stat.busy = cnt_reg != '0;
    assign stat.done = cnt_reg == DIV_STEP_W'(1);
    assign quot      = quot_reg;

endmodule

`default_nettype wire

>>> hw/rtl/imd_classify.sv
// Duty windows and device state decode from frequency, period and high time.
`default_nettype none

module imd_classify
    import imd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic [COUNT_WIDTH-1:0] period_ticks,
    input  wire logic [COUNT_WIDTH-1:0] high_ticks,
    input  wire logic                   pin_level,
    input  wire logic [FREQ_SHIFT:0]    freq_quot,   // top bit set: 64 Hz or more
    output cls_t                        cls
);

    localparam int MW = COUNT_WIDTH + 7;

    logic [MW-1:0]         p;
    logic [MW-1:0]         h;
    logic                  freq_zero;
    logic [FREQ_SHIFT-1:0] freq;
    logic                  a5;
    logic                  b95;
    logic                  b10;
    logic                  a90;
    logic                  a475;
    logic                  b525;
    logic                  g7;
    logic                  in5_95;

    assign p = MW'(period_ticks);
    assign h = MW'(high_ticks);

    // Duty windows, each as an exact cross-multiplied compare.
    assign a5   = h * MW'(20)  >= p;
    assign b95  = h * MW'(20)  <= p * MW'(19);
    assign b10  = h * MW'(10)  <= p;
    assign a90  = h * MW'(10)  >= p * MW'(9);
    assign a475 = h * MW'(40)  >= p * MW'(19);
    assign b525 = h * MW'(40)  <= p * MW'(21);
    assign g7   = h * MW'(100) >  p * MW'(7);

    assign in5_95    = a5 && b95;
    assign freq_zero = period_ticks == '0;
    assign freq      = freq_zero ? FREQ_NONE : freq_quot[FREQ_SHIFT-1:0];

    always_comb
    begin
        cls.st = DS_MEAS_ERR;
        if (freq_zero || !freq_quot[FREQ_SHIFT])
        begin
            case (freq)
                FREQ_NONE:   cls.st = pin_level ? DS_MEAS_ERR : DS_OFF;
                FREQ_NORMAL: cls.st = in5_95 ? DS_NORMAL : DS_MEAS_ERR;
                FREQ_UNDERV: cls.st = in5_95 ? DS_UNDERVOLT : DS_MEAS_ERR;
                FREQ_SPEED:  cls.st = (in5_95 && (b10 || a90)) ? DS_SPEED : DS_MEAS_ERR;
                FREQ_DEVERR: cls.st = (a475 && b525) ? DS_DEV_ERR : DS_MEAS_ERR;
                FREQ_EARTH:  cls.st = (a475 && b525) ? DS_EARTH : DS_MEAS_ERR;
                default:     cls.st = DS_MEAS_ERR;
            endcase
        end
        cls.need_res = (cls.st == DS_NORMAL || cls.st == DS_UNDERVOLT) && g7;
        cls.spd_high = a90;
    end

endmodule

`default_nettype wire

>>> tb/tb_insulation_monitor_pwm_decoder_top.sv
// Self-checking testbench of the insulation monitor PWM decoder top level.
`timescale 1ns / 1ps

module tb_insulation_monitor_pwm_decoder_top;
    import imd_pkg::*;

    // One decoded result as it travels on the master-side stream.
    typedef struct packed {
        dev_state_t             st;
        logic [RES_W-1:0]       res;
        logic                   flt;
    } meas_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    // period_ticks [15:0], high_ticks [31:16], pin_level [32], zero pad [39:33]
    logic [39:0]            s_axis_tdata = '0;

    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // device_state [2:0], resistance_kohm [18:3], fault [19], zero pad [23:20]
    wire  [23:0]            m_axis_tdata;

    logic                   cfg_valid = 1'b0;
    wire                    cfg_ready;
    logic                   cfg_addr = CFG_IDX_CLOCK;
    logic [CLOCK_W-1:0]     cfg_data = '0;

    // Shadow copy of the configuration and of the held measurement.
    logic [CLOCK_W-1:0]     timer_hz = CLOCK_RST;
    logic [PRESC_W-1:0]     timer_presc = PRESC_RST;
    logic [RES_W-1:0]       held_res_kohm = RES_UNMEASURED;
    logic                   held_fault_flag = 1'b0;

    meas_result_t           expected_results[$];

    // Idling intensity of each side: 0 never, 1 light, 2 heavy.
    int                     tx_idle_mode = 0;
    int                     rx_idle_mode = 0;
    int                     rx_hold = 0;

    int                     items_sent = 0;
    int                     results_checked = 0;
    int                     mismatches = 0;
    int                     settings_used = 1;
    int                     state_seen[0:7];

    insulation_monitor_pwm_decoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data)
    );

    always #2 clk = ~clk;

    // Duty windows are compared exactly: num/den <= high/period means den*high >= num*period.
    function automatic bit duty_ge(longint unsigned h, longint unsigned p,
                                   longint unsigned num, longint unsigned den);
        return den * h >= num * p;
    endfunction

    function automatic bit duty_le(longint unsigned h, longint unsigned p,
                                   longint unsigned num, longint unsigned den);
        return den * h <= num * p;
    endfunction

    // Works out the result that one measurement must produce and updates the held values.
    function automatic meas_result_t decode_measurement(logic [15:0] period,
                                                        logic [15:0] high, logic pin);
        longint unsigned p;
        longint unsigned h;
        longint unsigned clock_hz;
        longint unsigned presc;
        longint unsigned freq;
        longint unsigned quot;
        bit              in_band;
        meas_result_t    r;
        p = period;
        h = high;
        clock_hz = timer_hz;
        presc = timer_presc;
        freq = 0;
        if (p != 0)
            freq = clock_hz / ((presc + 1) * p);
        in_band = duty_ge(h, p, 1, 20) && duty_le(h, p, 19, 20);

        r.st = DS_MEAS_ERR;
        r.res = RES_UNMEASURED;
        r.flt = 1'b0;
        if (freq == FREQ_NONE)
            r.st = pin ? DS_MEAS_ERR : DS_OFF;
        else if (freq == FREQ_NORMAL && in_band)
            r.st = DS_NORMAL;
        else if (freq == FREQ_UNDERV && in_band)
            r.st = DS_UNDERVOLT;
        else if (freq == FREQ_SPEED && in_band
                 && (duty_le(h, p, 1, 10) || duty_ge(h, p, 9, 10)))
            r.st = DS_SPEED;
        else if ((freq == FREQ_DEVERR || freq == FREQ_EARTH)
                 && duty_ge(h, p, 19, 40) && duty_le(h, p, 21, 40))
            r.st = (freq == FREQ_DEVERR) ? DS_DEV_ERR : DS_EARTH;

        // A measurement error repeats the last good resistance and fault flag.
        if (r.st == DS_MEAS_ERR) begin
            r.res = held_res_kohm;
            r.flt = held_fault_flag;
            return r;
        end

        // At or below a duty of 7 percent the resistance is out of range and reads as unmeasured.
        if ((r.st == DS_NORMAL || r.st == DS_UNDERVOLT) && 100 * h > 7 * p) begin
            quot = (RES_SCALE * p) / (20 * h - p);
            r.res = (quot >= RES_OFFSET) ? RES_W'(quot - RES_OFFSET) : '0;
        end
        r.flt = (r.st == DS_SPEED && duty_ge(h, p, 9, 10)) || r.st == DS_EARTH
                || r.res < FAULT_LIMIT;
        held_res_kohm = r.res;
        held_fault_flag = r.flt;
        return r;
    endfunction

    // Idle length: mostly a few cycles, now and then a long pause.
    function automatic int pick_gap();
        if ($urandom_range(99, 0) < 88)
            return $urandom_range(3, 1);
        return $urandom_range(50, 15);
    endfunction

    // Sends one measurement item and records its expected result at acceptance.
    // The valid flag stays high across back-to-back items and is lowered only for a gap.
    task automatic send_meas(input logic [15:0] period, input logic [15:0] high,
                             input logic pin);
        int gap;
        gap = 0;
        if (tx_idle_mode != 0 && $urandom_range(99, 0) < (tx_idle_mode == 2 ? 40 : 15))
            gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, pin, high, period};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(decode_measurement(period, high, pin));
        items_sent++;
    endtask

    // Stops sending and waits until every outstanding result has been checked.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes both timer registers; only called while the decoder is idle.
    task automatic program_timer(input logic [CLOCK_W-1:0] clock_hz,
                                 input logic [PRESC_W-1:0] presc);
        cfg_valid <= 1'b1;
        cfg_addr <= CFG_IDX_CLOCK;
        cfg_data <= clock_hz;
        do
            @(posedge clk);
        while (!cfg_ready);
        timer_hz = clock_hz;
        cfg_addr <= CFG_IDX_PRESC;
        cfg_data <= CLOCK_W'(presc);
        do
            @(posedge clk);
        while (!cfg_ready);
        timer_presc = presc;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Picks one measurement for the present timer setting. Most items aim at one of the
    // meaningful frequencies with a duty near or inside its window, so that every device
    // state is reached; the rest are unaimed or carry no signal at all.
    task automatic send_random_meas();
        longint unsigned tick_hz;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned num_lo;
        longint unsigned num_hi;
        longint unsigned den;
        longint unsigned hmin;
        longint unsigned hmax;
        longint unsigned f;
        int              kind;
        int              r;
        logic [15:0]     p;
        logic [15:0]     h;
        tick_hz = longint'(timer_hz) / (longint'(timer_presc) + 1);
        kind = $urandom_range(99, 0);
        p = 16'($urandom_range(65535, 0));
        h = 16'($urandom_range(65535, 0));
        f = 10 * $urandom_range(5, 1);
        lo = tick_hz / (f + 1) + 1;
        hi = tick_hz / f;
        if (hi > 65535)
            hi = 65535;

        if (kind < 10) begin
            // Unaimed item: both counts fully random.
        end else if (kind < 16) begin
            // No signal, or a period so long that the frequency rounds down to zero.
            p = ($urandom_range(1, 0) == 1) ? 16'd0 : 16'hFFFF;
        end else if (lo <= hi) begin
            r = $urandom_range(99, 0);
            if (r < 8 && lo > 1)
                p = 16'(lo - 1);
            else if (r < 16 && hi < 65535)
                p = 16'(hi + 1);
            else if (r < 26)
                p = 16'((r < 21) ? lo : hi);
            else
                p = 16'($urandom_range(int'(hi), int'(lo)));

            den = 20;
            num_lo = 1;
            num_hi = 19;
            if (f == FREQ_SPEED) begin
                case ($urandom_range(2, 0))
                    0: num_hi = 2;
                    1: num_lo = 18;
                    default: ;
                endcase
            end else if (f == FREQ_DEVERR || f == FREQ_EARTH) begin
                den = 40;
                num_lo = 19;
                num_hi = 21;
            end
            hmin = (num_lo * p + den - 1) / den;
            hmax = (num_hi * p) / den;
            r = $urandom_range(99, 0);
            if (hmin > hmax)
                h = 16'($urandom_range(int'(p), 0));
            else if (r < 65)
                h = 16'($urandom_range(int'(hmax), int'(hmin)));
            else if (r < 75)
                h = 16'((r < 70) ? hmin : hmax);
            else if (r < 85)
                h = 16'((r < 80 && hmin > 0) ? hmin - 1 : hmax + 1);
            else if (r < 92)
                h = 16'($urandom_range(int'(p), 0));
        end
        send_meas(p, h, 1'($urandom_range(1, 0)));
    endtask

    task automatic run_random(input int count);
        repeat (count)
            send_random_meas();
        wait_all_results();
    endtask

    // Edge cases at the reset timer setting, where one tick is 20 us (50 kHz):
    // 10 Hz spans periods 4546..5000, 20 Hz 2381..2500, 30 Hz 1613..1666,
    // 40 Hz 1220..1250 and 50 Hz 981..1000.
    task automatic test_directed_cases();
        tx_idle_mode = 0;
        rx_idle_mode = 0;
        send_meas(16'd0, 16'd0, 1'b0);          // no signal with the line low: off
        send_meas(16'd0, 16'hFFFF, 1'b1);       // no signal with the line high: error
        send_meas(16'hFFFF, 16'hFFFF, 1'b0);    // longest period rounds to 0 Hz
        send_meas(16'hFFFF, 16'd0, 1'b1);
        send_meas(16'd5000, 16'd2500, 1'b0);    // normal at half duty
        send_meas(16'd5000, 16'd250, 1'b1);     // normal at exactly 5 percent
        send_meas(16'd5000, 16'd249, 1'b0);     // just below the window
        send_meas(16'd5000, 16'd350, 1'b0);     // exactly 7 percent, not measured
        send_meas(16'd5000, 16'd351, 1'b0);     // just above 7 percent, near top resistance
        send_meas(16'd5000, 16'd4750, 1'b1);    // 95 percent, zero resistance and fault
        send_meas(16'd5000, 16'd4751, 1'b0);    // error holds the fault just set
        send_meas(16'd4546, 16'd2273, 1'b0);    // shortest period still at 10 Hz
        send_meas(16'd2500, 16'd1250, 1'b0);    // undervoltage
        send_meas(16'd2381, 16'd2261, 1'b1);    // undervoltage, top of window
        send_meas(16'd1640, 16'd82, 1'b0);      // speed start, low band edges
        send_meas(16'd1640, 16'd164, 1'b0);
        send_meas(16'd1640, 16'd165, 1'b0);     // between the two speed bands
        send_meas(16'd1640, 16'd1476, 1'b0);    // speed start, high band raises the fault
        send_meas(16'd1640, 16'd1558, 1'b0);
        send_meas(16'd1250, 16'd594, 1'b0);     // device error, lower duty edge
        send_meas(16'd1250, 16'd657, 1'b0);     // just above the device error window
        send_meas(16'd1000, 16'd475, 1'b1);     // earth fault edges
        send_meas(16'd1000, 16'd525, 1'b0);
        send_meas(16'd5000, 16'd6000, 1'b0);    // high time longer than the period
        send_meas(16'd1, 16'd0, 1'b1);          // far too fast
        wait_all_results();
    endtask

    task automatic test_default_timer();
        tx_idle_mode = 1;
        rx_idle_mode = 1;
        run_random(450);
    endtask

    // Slowest tick for the largest clock: short periods, 30 Hz only at a period of 36.
    task automatic test_slowest_tick();
        program_timer(27'd72000000, 16'hFFFF);
        tx_idle_mode = 2;
        rx_idle_mode = 2;
        run_random(350);
    endtask

    // Long periods near the top of the count range, run without any idling.
    task automatic test_long_periods();
        program_timer(27'd500000, 16'd0);
        tx_idle_mode = 0;
        rx_idle_mode = 0;
        run_random(350);
    endtask

    // Settings under which no meaningful frequency can occur at all.
    task automatic test_unreachable_settings();
        program_timer(27'd72000000, 16'd0);
        tx_idle_mode = 1;
        rx_idle_mode = 2;
        run_random(150);
        program_timer(27'd1, 16'hFFFF);
        run_random(150);
        program_timer(27'd1, 16'd0);
        run_random(50);
    endtask

    task automatic test_mid_setting();
        program_timer(27'd1000000, 16'd99);
        tx_idle_mode = 2;
        rx_idle_mode = 1;
        run_random(350);
    endtask

    // Result receiver: random stalls of the output, driven at the rising edge.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_idle_mode != 0
                     && $urandom_range(99, 0) < (rx_idle_mode == 2 ? 40 : 15)) begin
            m_axis_tready <= 1'b0;
            rx_hold <= pick_gap() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Checks every accepted result against the oldest outstanding expectation.
    always @(posedge clk) begin : check_result
        meas_result_t got;
        meas_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.st = dev_state_t'(m_axis_tdata[2:0]);
            got.res = m_axis_tdata[18:3];
            got.flt = m_axis_tdata[19];
            state_seen[m_axis_tdata[2:0]]++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: state %0d res %0d fault %0b",
                             $time, got.st, got.res, got.flt);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("%0t: result %0d wrong: state %0d/%0d ",
                               $time, results_checked, want.st, got.st);
                        $display("res %0d/%0d fault %0b/%0b (expected/actual)",
                                 want.res, got.res, want.flt, got.flt);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        foreach (state_seen[i])
            state_seen[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_default_timer();
        test_slowest_tick();
        test_long_periods();
        test_unreachable_settings();
        test_mid_setting();

        // Any stray result would show up within the longest item time.
        repeat (60) @(posedge clk);

        $display("Sent %0d measurements under %0d timer settings, checked %0d results",
                 items_sent, settings_used, results_checked);
        $write("States seen: off %0d, normal %0d, undervoltage %0d, speed start %0d, ",
               state_seen[0], state_seen[1], state_seen[2], state_seen[3]);
        $display("device error %0d, earth fault %0d, error %0d",
                 state_seen[4], state_seen[5], state_seen[6]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
